// File: rtl/core/block_sum_downscale_defines.svh
// ----------------------------------------------------------------------------
// block_sum_downscale assertion macros
// Shared property wrappers, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SUM_DOWNSCALE_DEFINES_SVH
`define BLOCK_SUM_DOWNSCALE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants, register map and types of the block sum downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

    localparam int MAX_SMALL_WIDTH_DEF = 1024;
    localparam int MAX_FACTOR_DEF      = 8;
    localparam int HEIGHT_LIMIT        = 1024;
    localparam int ROW_W               = 10;
    localparam int GRAD_W              = 16;
    localparam int SUM_W               = 22;
    localparam int SIZE_REG_W          = 11;
    localparam int FACTOR_REG_W        = 4;
    localparam int ADDR_W              = 5;
    localparam int DATA_W              = 32;

    typedef enum logic [2:0] {
        REG_SMALL_WIDTH  = 3'd0,
        REG_SMALL_HEIGHT = 3'd1,
        REG_FACTOR_W     = 3'd2,
        REG_FACTOR_H     = 3'd3,
        REG_PROPAGATE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic first;
        logic last_plane;
        logic emit;
    } t_pos_flags;

endpackage

`default_nettype wire

// File: rtl/core/bsd_cfg.sv
// ----------------------------------------------------------------------------
// bsd_cfg
// APB register file with clamped, minus-one geometry for the position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_cfg #(
    parameter int MAX_SMALL_WIDTH = bsd_pkg::MAX_SMALL_WIDTH_DEF,
    parameter int MAX_FACTOR      = bsd_pkg::MAX_FACTOR_DEF,
    localparam int CW = (MAX_SMALL_WIDTH > 1) ? $clog2(MAX_SMALL_WIDTH) : 1,
    localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bsd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bsd_pkg::DATA_W-1:0]  pwdata,
    output logic      [bsd_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [CW-1:0]               o_w_m1,
    output logic      [bsd_pkg::ROW_W-1:0]   o_h_m1,
    output logic      [FW-1:0]               o_fw_m1,
    output logic      [FW-1:0]               o_fh_m1,
    output logic                             o_propagate,
    output logic                             o_clear
);

    localparam int SWCW = (CW + 1 > bsd_pkg::SIZE_REG_W) ? CW + 1 : bsd_pkg::SIZE_REG_W;
    localparam int FCW  = (FW + 1 > bsd_pkg::FACTOR_REG_W) ? FW + 1 : bsd_pkg::FACTOR_REG_W;

    logic [bsd_pkg::SIZE_REG_W-1:0]   r_small_width;
    logic [bsd_pkg::SIZE_REG_W-1:0]   r_small_height;
    logic [bsd_pkg::FACTOR_REG_W-1:0] r_factor_w;
    logic [bsd_pkg::FACTOR_REG_W-1:0] r_factor_h;
    logic                             r_propagate;

    logic                             wr_en;
    bsd_pkg::t_reg_idx                reg_idx;
    logic [SWCW-1:0]                  w_ext;
    logic [SWCW-1:0]                  w_clamp;
    logic [SWCW-1:0]                  w_m1_ext;
    logic [bsd_pkg::SIZE_REG_W-1:0]   h_clamp;
    logic [bsd_pkg::SIZE_REG_W-1:0]   h_m1_ext;
    logic [FCW-1:0]                   fw_ext;
    logic [FCW-1:0]                   fh_ext;
    logic [FCW-1:0]                   fw_clamp;
    logic [FCW-1:0]                   fh_clamp;
    logic [FCW-1:0]                   fw_m1_ext;
    logic [FCW-1:0]                   fh_m1_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bsd_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_width  <= bsd_pkg::SIZE_REG_W'(1);
            r_small_height <= bsd_pkg::SIZE_REG_W'(1);
            r_factor_w     <= bsd_pkg::FACTOR_REG_W'(1);
            r_factor_h     <= bsd_pkg::FACTOR_REG_W'(1);
            r_propagate    <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                bsd_pkg::REG_SMALL_WIDTH:  r_small_width  <= pwdata[bsd_pkg::SIZE_REG_W-1:0];
                bsd_pkg::REG_SMALL_HEIGHT: r_small_height <= pwdata[bsd_pkg::SIZE_REG_W-1:0];
                bsd_pkg::REG_FACTOR_W:     r_factor_w     <= pwdata[bsd_pkg::FACTOR_REG_W-1:0];
                bsd_pkg::REG_FACTOR_H:     r_factor_h     <= pwdata[bsd_pkg::FACTOR_REG_W-1:0];
                bsd_pkg::REG_PROPAGATE:    r_propagate    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_clear = 1'b0;
        if (wr_en) begin
            unique case (reg_idx) inside
                bsd_pkg::REG_SMALL_WIDTH,
                bsd_pkg::REG_SMALL_HEIGHT,
                bsd_pkg::REG_FACTOR_W,
                bsd_pkg::REG_FACTOR_H,
                bsd_pkg::REG_PROPAGATE: o_clear = 1'b1;
                default:                o_clear = 1'b0;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bsd_pkg::REG_SMALL_WIDTH:  prdata = bsd_pkg::DATA_W'(r_small_width);
            bsd_pkg::REG_SMALL_HEIGHT: prdata = bsd_pkg::DATA_W'(r_small_height);
            bsd_pkg::REG_FACTOR_W:     prdata = bsd_pkg::DATA_W'(r_factor_w);
            bsd_pkg::REG_FACTOR_H:     prdata = bsd_pkg::DATA_W'(r_factor_h);
            bsd_pkg::REG_PROPAGATE:    prdata = bsd_pkg::DATA_W'(r_propagate);
            default:                   prdata = '0;
        endcase
    end

    // zero reads as one, oversize reads as the limit
    always_comb begin
        w_ext = SWCW'(r_small_width);
        if (w_ext == '0) begin
            w_clamp = SWCW'(1);
        end else if (w_ext > SWCW'(MAX_SMALL_WIDTH)) begin
            w_clamp = SWCW'(MAX_SMALL_WIDTH);
        end else begin
            w_clamp = w_ext;
        end
        w_m1_ext = w_clamp - SWCW'(1);

        if (r_small_height == '0) begin
            h_clamp = bsd_pkg::SIZE_REG_W'(1);
        end else if (r_small_height > bsd_pkg::SIZE_REG_W'(bsd_pkg::HEIGHT_LIMIT)) begin
            h_clamp = bsd_pkg::SIZE_REG_W'(bsd_pkg::HEIGHT_LIMIT);
        end else begin
            h_clamp = r_small_height;
        end
        h_m1_ext = h_clamp - bsd_pkg::SIZE_REG_W'(1);

        fw_ext = FCW'(r_factor_w);
        if (fw_ext == '0) begin
            fw_clamp = FCW'(1);
        end else if (fw_ext > FCW'(MAX_FACTOR)) begin
            fw_clamp = FCW'(MAX_FACTOR);
        end else begin
            fw_clamp = fw_ext;
        end
        fw_m1_ext = fw_clamp - FCW'(1);

        fh_ext = FCW'(r_factor_h);
        if (fh_ext == '0) begin
            fh_clamp = FCW'(1);
        end else if (fh_ext > FCW'(MAX_FACTOR)) begin
            fh_clamp = FCW'(MAX_FACTOR);
        end else begin
            fh_clamp = fh_ext;
        end
        fh_m1_ext = fh_clamp - FCW'(1);
    end

    assign o_w_m1      = w_m1_ext[CW-1:0];
    assign o_h_m1      = h_m1_ext[bsd_pkg::ROW_W-1:0];
    assign o_fw_m1     = fw_m1_ext[FW-1:0];
    assign o_fh_m1     = fh_m1_ext[FW-1:0];
    assign o_propagate = r_propagate;

endmodule

`default_nettype wire

// File: rtl/core/bsd_pos.sv
// ----------------------------------------------------------------------------
// bsd_pos
// Row-major position counters over the large plane and per-beat block flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_pos #(
    parameter int MAX_SMALL_WIDTH = bsd_pkg::MAX_SMALL_WIDTH_DEF,
    parameter int MAX_FACTOR      = bsd_pkg::MAX_FACTOR_DEF,
    localparam int CW = (MAX_SMALL_WIDTH > 1) ? $clog2(MAX_SMALL_WIDTH) : 1,
    localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic                      i_adv,
    input  wire logic [CW-1:0]             i_w_m1,
    input  wire logic [bsd_pkg::ROW_W-1:0] i_h_m1,
    input  wire logic [FW-1:0]             i_fw_m1,
    input  wire logic [FW-1:0]             i_fh_m1,
    input  wire logic                      i_propagate,
    output logic      [CW-1:0]             o_col,
    output bsd_pkg::t_pos_flags            o_flags
);

    logic [CW-1:0]             r_small_col;
    logic [FW-1:0]             r_sub_col;
    logic [FW-1:0]             r_sub_row;
    logic [bsd_pkg::ROW_W-1:0] r_small_row;

    logic [CW-1:0]             n_small_col;
    logic [FW-1:0]             n_sub_col;
    logic [FW-1:0]             n_sub_row;
    logic [bsd_pkg::ROW_W-1:0] n_small_row;

    logic end_sub_col;
    logic end_small_col;
    logic end_sub_row;
    logic end_small_row;
    logic last_block;

    assign end_sub_col   = (r_sub_col == i_fw_m1);
    assign end_small_col = (r_small_col == i_w_m1);
    assign end_sub_row   = (r_sub_row == i_fh_m1);
    assign end_small_row = (r_small_row == i_h_m1);
    assign last_block    = end_sub_col && end_sub_row;

    assign o_col              = r_small_col;
    assign o_flags.first      = (r_sub_col == '0) && (r_sub_row == '0);
    assign o_flags.last_plane = last_block && end_small_col && end_small_row;
    assign o_flags.emit       = last_block && i_propagate;

    always_comb begin
        n_small_col = r_small_col;
        n_sub_col   = r_sub_col;
        n_sub_row   = r_sub_row;
        n_small_row = r_small_row;
        if (end_sub_col) begin
            n_sub_col = '0;
            if (end_small_col) begin
                n_small_col = '0;
                if (end_sub_row) begin
                    n_sub_row   = '0;
                    n_small_row = end_small_row ? '0 : r_small_row + 1'b1;
                end else begin
                    n_sub_row = r_sub_row + 1'b1;
                end
            end else begin
                n_small_col = r_small_col + 1'b1;
            end
        end else begin
            n_sub_col = r_sub_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_small_col <= '0;
            r_sub_col   <= '0;
            r_sub_row   <= '0;
            r_small_row <= '0;
        end else if (i_adv) begin
            r_small_col <= n_small_col;
            r_sub_col   <= n_sub_col;
            r_sub_row   <= n_sub_row;
            r_small_row <= n_small_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bsd_accum.sv
// ----------------------------------------------------------------------------
// bsd_accum
// Line of partial sums, saturating accumulate stage and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_sum_downscale_defines.svh"

module bsd_accum #(
    parameter int MAX_SMALL_WIDTH = bsd_pkg::MAX_SMALL_WIDTH_DEF,
    localparam int CW = (MAX_SMALL_WIDTH > 1) ? $clog2(MAX_SMALL_WIDTH) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic signed [bsd_pkg::GRAD_W-1:0] i_grad_in,
    input  wire logic        [CW-1:0]             i_col,
    input  wire bsd_pkg::t_pos_flags              i_flags,
    output logic                                  o_accept,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [bsd_pkg::SUM_W-1:0]      o_grad_sum,
    output logic                                  o_plane_last
);

    logic signed [bsd_pkg::SUM_W-1:0] r_line [MAX_SMALL_WIDTH];

    // accumulate stage
    logic                              r_a_valid;
    logic signed [bsd_pkg::GRAD_W-1:0] r_a_grad;
    logic        [CW-1:0]              r_a_col;
    bsd_pkg::t_pos_flags               r_a_flags;
    logic signed [bsd_pkg::SUM_W-1:0]  r_rd_data;
    logic                              r_fwd;
    logic signed [bsd_pkg::SUM_W-1:0]  r_fwd_data;

    // result register
    logic                              r_o_valid;
    logic signed [bsd_pkg::SUM_W-1:0]  r_o_sum;
    logic                              r_o_last;

    logic                              adv_a;
    logic                              load_o;
    logic signed [bsd_pkg::SUM_W-1:0]  base;
    logic signed [bsd_pkg::SUM_W:0]    raw_sum;
    logic signed [bsd_pkg::SUM_W-1:0]  sat_sum;
    logic signed [bsd_pkg::SUM_W-1:0]  sum;

    assign adv_a      = r_a_valid && (!r_a_flags.emit || !r_o_valid || !i_out_stall);
    assign load_o     = adv_a && r_a_flags.emit;
    assign o_in_stall = r_a_valid && !adv_a;
    assign o_accept   = i_in_valid && !o_in_stall;

    assign base    = r_fwd ? r_fwd_data : r_rd_data;
    assign raw_sum = (bsd_pkg::SUM_W + 1)'(base) + (bsd_pkg::SUM_W + 1)'(r_a_grad);

    always_comb begin
        if (raw_sum[bsd_pkg::SUM_W] != raw_sum[bsd_pkg::SUM_W-1]) begin
            sat_sum = raw_sum[bsd_pkg::SUM_W] ?
                      {1'b1, {(bsd_pkg::SUM_W-1){1'b0}}} :
                      {1'b0, {(bsd_pkg::SUM_W-1){1'b1}}};
        end else begin
            sat_sum = raw_sum[bsd_pkg::SUM_W-1:0];
        end
        sum = r_a_flags.first ? bsd_pkg::SUM_W'(r_a_grad) : sat_sum;
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_line[r_a_col] <= sum;
        end
        if (o_accept) begin
            r_rd_data <= r_line[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (o_accept) begin
                r_a_valid <= 1'b1;
                // same-edge write to the column being read
                r_fwd     <= adv_a && (r_a_col == i_col);
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_a_grad   <= i_grad_in;
            r_a_col    <= i_col;
            r_a_flags  <= i_flags;
            r_fwd_data <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_o) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_o) begin
            r_o_sum  <= sum;
            r_o_last <= r_a_flags.last_plane;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_grad_sum   = r_o_sum;
    assign o_plane_last = r_o_last;

    `BSD_ASSERT_NOW(a_stall_has_item, o_in_stall, r_a_valid, "stall without a held item")
    `BSD_ASSERT_NOW(a_no_overwrite, r_o_valid && i_out_stall, !load_o, "held result overwritten")
    `BSD_ASSERT_NEXT(a_hold_item, r_a_valid && !adv_a, r_a_valid && $stable(r_a_col), "held item lost")
    `BSD_ASSERT_NOW(a_result_source, $rose(r_o_valid), $past(load_o), "result without a block end")

endmodule

`default_nettype wire

// File: rtl/core/block_sum_downscale.sv
// ----------------------------------------------------------------------------
// block_sum_downscale
// Non-overlapping 2-D sum pooling of a gradient plane into a small plane.
// ----------------------------------------------------------------------------
// Samples of the large plane enter on i_grad_in (valid/stall), row-major,
// planes back to back; each factor_w by factor_h block gives one sum on
// o_grad_sum (valid/stall), with o_plane_last on the last element of a plane.
// Samples that do not close a block, and all samples while propagate is 0,
// give no result beat.
// Throughput is one sample per cycle unless o_in_stall holds the input. The
// edge that takes a block's last sample loads the accumulate stage and reads
// the line; the result register is loaded when that stage moves on.
// Partial sums live in a line memory, one entry per small column; the first
// sample of a block writes its entry, so no clearing pass is needed.
// When the receiver stalls, the accumulate stage still drains samples that
// close no block; the input stalls only when a finished sum waits behind a
// full result register. Reset empties both stages and returns the position
// to the start of a plane, with registers at one (propagate on). Any write of
// a known register also restarts the position. Write registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_sum_downscale #(
    parameter int MAX_SMALL_WIDTH = bsd_pkg::MAX_SMALL_WIDTH_DEF,
    parameter int MAX_FACTOR      = bsd_pkg::MAX_FACTOR_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic        [bsd_pkg::ADDR_W-1:0] paddr,
    input  wire logic        [bsd_pkg::DATA_W-1:0] pwdata,
    output logic             [bsd_pkg::DATA_W-1:0] prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [bsd_pkg::GRAD_W-1:0] i_grad_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed      [bsd_pkg::SUM_W-1:0]  o_grad_sum,
    output logic                                   o_plane_last
);

    localparam int CW = (MAX_SMALL_WIDTH > 1) ? $clog2(MAX_SMALL_WIDTH) : 1;
    localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

    logic [CW-1:0]             w_m1;
    logic [bsd_pkg::ROW_W-1:0] h_m1;
    logic [FW-1:0]             fw_m1;
    logic [FW-1:0]             fh_m1;
    logic                      propagate;
    logic                      clear;
    logic                      accept;
    logic [CW-1:0]             col;
    bsd_pkg::t_pos_flags       flags;

    bsd_cfg #(
        .MAX_SMALL_WIDTH (MAX_SMALL_WIDTH),
        .MAX_FACTOR      (MAX_FACTOR)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_w_m1      (w_m1),
        .o_h_m1      (h_m1),
        .o_fw_m1     (fw_m1),
        .o_fh_m1     (fh_m1),
        .o_propagate (propagate),
        .o_clear     (clear)
    );

    bsd_pos #(
        .MAX_SMALL_WIDTH (MAX_SMALL_WIDTH),
        .MAX_FACTOR      (MAX_FACTOR)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_adv       (accept),
        .i_w_m1      (w_m1),
        .i_h_m1      (h_m1),
        .i_fw_m1     (fw_m1),
        .i_fh_m1     (fh_m1),
        .i_propagate (propagate),
        .o_col       (col),
        .o_flags     (flags)
    );

    bsd_accum #(
        .MAX_SMALL_WIDTH (MAX_SMALL_WIDTH)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_grad_in    (i_grad_in),
        .i_col        (col),
        .i_flags      (flags),
        .o_accept     (accept),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_grad_sum   (o_grad_sum),
        .o_plane_last (o_plane_last)
    );

endmodule

`default_nettype wire
